@@ design/sfd_pkg.sv @@
// Shared types, constants and rounding helpers for the stereo feedback delay.
`timescale 1ns / 1ps

package sfd_pkg;

    // Sample and store geometry (store depth is a power of two)
    localparam int SAMPLE_W    = 24;
    localparam int ADDR_W      = 18;
    localparam int DELAY_DEPTH = 2 ** ADDR_W;
    localparam int LANES       = 2;

    // Gain formats: unsigned, 16 fraction bits, one integer bit for unity
    localparam int FRAC_W  = 16;
    localparam int GAIN_W  = FRAC_W + 1;
    localparam int COEF_W  = GAIN_W + 1;
    localparam int PROD_W  = SAMPLE_W + COEF_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int RND_W   = ACC_W - FRAC_W;
    localparam int WHOLE_W = 18;

    // Front-to-back job queue
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_WHOLE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_FRAC    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_GAIN      = CFG_IDX_W'(3);

    localparam logic [WHOLE_W-1:0] RST_DELAY_WHOLE   = WHOLE_W'(24000);
    localparam logic [FRAC_W-1:0]  RST_DELAY_FRAC    = FRAC_W'(0);
    localparam logic [FRAC_W-1:0]  RST_FEEDBACK_GAIN = FRAC_W'(0);
    localparam logic [GAIN_W-1:0]  RST_MIX_GAIN      = GAIN_W'(32768);

    localparam logic [GAIN_W-1:0] GAIN_ONE       = GAIN_W'(2 ** FRAC_W);
    localparam logic [FRAC_W-1:0] FEEDBACK_LIMIT = FRAC_W'(64880);

    // Rounding and saturation constants
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (FRAC_W - 1));
    localparam logic signed [RND_W-1:0] SAT_HI   =
        RND_W'((longint'(1) << (SAMPLE_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] SAT_LO   = -SAT_HI - RND_W'(1);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [ADDR_W-1:0]          t_addr;

    typedef struct packed {
        t_sample left_in;
        t_sample right_in;
    } t_in;

    typedef struct packed {
        t_sample left_out;
        t_sample right_out;
    } t_out;

    // Live configuration, gains already clamped
    typedef struct packed {
        logic [WHOLE_W-1:0] delay_whole;
        logic [FRAC_W-1:0]  frac;
        logic [GAIN_W-1:0]  frac_inv;
        logic [FRAC_W-1:0]  fb;
        logic [GAIN_W-1:0]  mix;
        logic [GAIN_W-1:0]  mix_inv;
    } t_cfg;

    // One classified frame waiting for the back end
    typedef struct packed {
        t_in   dry;
        t_addr wr_addr;
        t_addr near_addr;
        t_addr far_addr;
        logic  near_ok;
        logic  far_ok;
    } t_job;

    // floor((v + 2^15) / 2^16)
    function automatic logic signed [RND_W-1:0] rnd16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + RND_HALF;
        return t[ACC_W-1:FRAC_W];
    endfunction

    // Clamp to the signed sample range
    function automatic t_sample sat(input logic signed [RND_W-1:0] v);
        t_sample r;
        if (v > SAT_HI) begin
            r = SAT_HI[SAMPLE_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/sfd_cfg.sv @@
// Configuration registers with gain clamping and complement terms.
`timescale 1ns / 1ps

module sfd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output sfd_pkg::t_cfg                  o_cfg
);
    import sfd_pkg::*;

    logic [WHOLE_W-1:0] r_delay_whole;
    logic [FRAC_W-1:0]  r_delay_frac;
    logic [FRAC_W-1:0]  r_feedback_gain;
    logic [GAIN_W-1:0]  r_mix_gain;

    // Writes are always taken; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_whole   <= RST_DELAY_WHOLE;
            r_delay_frac    <= RST_DELAY_FRAC;
            r_feedback_gain <= RST_FEEDBACK_GAIN;
            r_mix_gain      <= RST_MIX_GAIN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DELAY_WHOLE:   r_delay_whole   <= i_cfg_data[WHOLE_W-1:0];
                CFG_DELAY_FRAC:    r_delay_frac    <= i_cfg_data[FRAC_W-1:0];
                CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_data[FRAC_W-1:0];
                CFG_MIX_GAIN:      r_mix_gain      <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp feedback to 0.99 and mix to unity, form the 1-x weights
    always_comb begin
        o_cfg.delay_whole = r_delay_whole;
        o_cfg.frac        = r_delay_frac;
        o_cfg.frac_inv    = GAIN_ONE - GAIN_W'(r_delay_frac);
        o_cfg.fb          = (r_feedback_gain > FEEDBACK_LIMIT) ? FEEDBACK_LIMIT
                                                                : r_feedback_gain;
        o_cfg.mix         = (r_mix_gain > GAIN_ONE) ? GAIN_ONE : r_mix_gain;
        o_cfg.mix_inv     = GAIN_ONE - o_cfg.mix;
    end

endmodule

@@ design/sfd_front.sv @@
// Front end: accepts frames, works out tap addresses and queues the jobs.
`timescale 1ns / 1ps

module sfd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfd_pkg::t_cfg i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sfd_pkg::t_in  i_in_data,
    output logic          o_job_valid,
    output sfd_pkg::t_job o_job,
    input  logic          i_job_pop
);
    import sfd_pkg::*;

    t_addr                r_wp;
    logic                 r_wrapped;
    t_job                 r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW:0]    r_count;

    logic  w_push;
    t_addr w_dw;
    t_job  w_job;

    assign o_in_stall  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_job_valid = (r_count != '0);
    assign o_job       = r_q[r_rd_ptr];
    assign w_push      = i_in_valid && !o_in_stall;

    // Tap addresses; an entry is unwritten until the write position has
    // passed it once, and then reads as zero
    always_comb begin
        w_dw            = ADDR_W'(i_cfg.delay_whole);
        w_job.dry       = i_in_data;
        w_job.wr_addr   = r_wp;
        w_job.near_addr = r_wp - w_dw;
        w_job.far_addr  = w_job.near_addr - ADDR_W'(1);
        w_job.near_ok   = r_wrapped || (w_job.near_addr < r_wp);
        w_job.far_ok    = r_wrapped || (w_job.far_addr < r_wp);
    end

    // Write position and fill tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else if (w_push) begin
            r_wp <= r_wp + ADDR_W'(1);
            if (r_wp == '1) begin
                r_wrapped <= 1'b1;
            end
        end
    end

    // Job queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_job_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (w_push && !i_job_pop) begin
                r_count <= r_count + (QUEUE_AW + 1)'(1);
            end else if (!w_push && i_job_pop) begin
                r_count <= r_count - (QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

@@ design/sfd_back.sv @@
// Back end: delay store, per-channel multiply-accumulate sequence, output register.
`timescale 1ns / 1ps

module sfd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sfd_pkg::t_cfg i_cfg,
    input  logic          i_job_valid,
    input  sfd_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_out_valid,
    output sfd_pkg::t_out o_out_data,
    input  logic          i_out_stall
);
    import sfd_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC0  = 3'd1;
    localparam logic [2:0] ST_MAC1  = 3'd2;
    localparam logic [2:0] ST_DLY   = 3'd3;
    localparam logic [2:0] ST_MIX   = 3'd4;
    localparam logic [2:0] ST_FB    = 3'd5;
    localparam logic [2:0] ST_WRITE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    logic [LANES*SAMPLE_W-1:0] r_mem [DELAY_DEPTH];
    logic [LANES*SAMPLE_W-1:0] r_rd_near;
    logic [LANES*SAMPLE_W-1:0] r_rd_far;

    t_job                    r_job;
    logic signed [ACC_W-1:0] r_acc     [LANES];
    t_sample                 r_delayed [LANES];
    t_sample                 r_mixed   [LANES];
    logic                    r_out_valid;
    t_out                    r_out;

    t_sample                  w_dry   [LANES];
    t_sample                  w_mul_a [LANES];
    logic signed [COEF_W-1:0] w_mul_b [LANES];
    logic signed [PROD_W-1:0] w_prod  [LANES];
    logic signed [ACC_W-1:0]  w_acc   [LANES];
    logic signed [RND_W-1:0]  w_rnd   [LANES];
    t_sample                  w_store [LANES];
    logic                     w_done;
    logic                     w_we;

    // One frame at a time: the next read only starts after the write-back
    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;
    assign w_done    = !r_out_valid || !i_out_stall;
    assign w_we      = (r_state == ST_WRITE) && w_done;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_job_valid) n_state = ST_MAC0;
            ST_MAC0:  n_state = ST_MAC1;
            ST_MAC1:  n_state = ST_DLY;
            ST_DLY:   n_state = ST_MIX;
            ST_MIX:   n_state = ST_FB;
            ST_FB:    n_state = ST_WRITE;
            ST_WRITE: if (w_done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Delay store: both taps read on job pickup, write-back at the end
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_job.wr_addr] <= {w_store[1], w_store[0]};
        end
        if (o_job_pop) begin
            r_rd_near <= r_mem[i_job.near_addr];
            r_rd_far  <= r_mem[i_job.far_addr];
            r_job     <= i_job;
        end
    end

    // Per-lane operand select and multiply-accumulate
    always_comb begin
        w_dry[0] = r_job.dry.left_in;
        w_dry[1] = r_job.dry.right_in;
        for (int ch = 0; ch < LANES; ch++) begin
            case (r_state)
                ST_MAC0: begin
                    w_mul_a[ch] = r_job.far_ok ? r_rd_far[ch*SAMPLE_W +: SAMPLE_W] : '0;
                    w_mul_b[ch] = COEF_W'(i_cfg.frac);
                end
                ST_MAC1: begin
                    w_mul_a[ch] = r_job.near_ok ? r_rd_near[ch*SAMPLE_W +: SAMPLE_W] : '0;
                    w_mul_b[ch] = COEF_W'(i_cfg.frac_inv);
                end
                ST_DLY: begin
                    w_mul_a[ch] = w_dry[ch];
                    w_mul_b[ch] = COEF_W'(i_cfg.mix_inv);
                end
                ST_MIX: begin
                    w_mul_a[ch] = r_delayed[ch];
                    w_mul_b[ch] = COEF_W'(i_cfg.mix);
                end
                ST_FB: begin
                    w_mul_a[ch] = r_delayed[ch];
                    w_mul_b[ch] = COEF_W'(i_cfg.fb);
                end
                default: begin
                    w_mul_a[ch] = '0;
                    w_mul_b[ch] = '0;
                end
            endcase
            w_prod[ch] = w_mul_a[ch] * w_mul_b[ch];
            if (r_state == ST_MAC1 || r_state == ST_MIX) begin
                w_acc[ch] = r_acc[ch] + ACC_W'(w_prod[ch]);
            end else begin
                w_acc[ch] = ACC_W'(w_prod[ch]);
            end
            w_rnd[ch]   = rnd16(r_acc[ch]);
            w_store[ch] = sat(RND_W'(w_dry[ch]) + w_rnd[ch]);
        end
    end

    // Lane datapath registers
    always_ff @(posedge i_clk) begin
        for (int ch = 0; ch < LANES; ch++) begin
            if (r_state inside {ST_MAC0, ST_MAC1, ST_DLY, ST_MIX, ST_FB}) begin
                r_acc[ch] <= w_acc[ch];
            end
            if (r_state == ST_DLY) begin
                r_delayed[ch] <= w_rnd[ch][SAMPLE_W-1:0];
            end
            if (r_state == ST_FB) begin
                r_mixed[ch] <= sat(w_rnd[ch]);
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_we) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_out.left_out  <= r_mixed[0];
            r_out.right_out <= r_mixed[1];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/stereo_feedback_delay.sv @@
// Top level of the stereo feedback delay with linear interpolation.
`timescale 1ns / 1ps

// Stereo feedback delay: each frame is delayed by delay_whole + delay_frac/65536
// samples, mixed with the dry signal by mix_gain and fed back by feedback_gain,
// all in 24-bit saturating fixed point. In the back end each frame first reads
// both interpolation taps from the 262144 x 48-bit delay store, then runs the
// multiply-accumulate sequence (MAC0, MAC1, DLY, MIX, FB) on one multiplier
// per channel, and last writes the store and loads the output register. Frames
// are handled one after another: the back end takes no new frame until it has
// written back the last one; a two-entry queue in front takes new frames while
// the back end is busy. No clearing pass is needed after reset: store entries
// the write position has not yet reached read as zero. Configuration writes
// are always accepted and must only be made while the block is idle.

module stereo_feedback_delay (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sfd_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sfd_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sfd_pkg::*;

    t_cfg w_cfg;
    logic w_job_valid;
    t_job w_job;
    logic w_job_pop;

    sfd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    sfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_job_valid (w_job_valid),
        .o_job       (w_job),
        .i_job_pop   (w_job_pop)
    );

    sfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_job_valid (w_job_valid),
        .i_job       (w_job),
        .o_job_pop   (w_job_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for the stereo feedback delay: predictor, drivers and checks.
`timescale 1ns / 1ps

module tb;

    import sfd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 32;
    localparam int SEGMENTS      = 8;
    localparam int SEG_FRAMES    = 60;
    localparam int HOLD_CYCLES   = 300;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(200);

    localparam t_sample S_MAX = 24'sh7FFFFF;
    localparam t_sample S_MIN = 24'sh800000;

    // Bit-exact model of the delay line plus the queue of expected output frames
    class delay_scoreboard;
        bit signed [SAMPLE_W-1:0] left_mem  [DELAY_DEPTH];
        bit signed [SAMPLE_W-1:0] right_mem [DELAY_DEPTH];
        t_addr              write_pos   = '0;
        logic [WHOLE_W-1:0] delay_whole = RST_DELAY_WHOLE;
        logic [FRAC_W-1:0]  delay_frac  = RST_DELAY_FRAC;
        logic [FRAC_W-1:0]  feedback    = RST_FEEDBACK_GAIN;
        logic [GAIN_W-1:0]  mix         = RST_MIX_GAIN;
        t_out               expected_frames [$];
        int                 errors      = 0;

        function int pending();
            return expected_frames.size();
        endfunction

        // floor((v + 2^15) / 2^16)
        function longint round16(longint v);
            return (v + 64'sd32768) >>> 16;
        endfunction

        function t_sample clamp(longint v);
            if (v > longint'(S_MAX)) return S_MAX;
            if (v < longint'(S_MIN)) return S_MIN;
            return t_sample'(v);
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_DELAY_WHOLE:   delay_whole = val[WHOLE_W-1:0];
                CFG_DELAY_FRAC:    delay_frac  = val[FRAC_W-1:0];
                CFG_FEEDBACK_GAIN: feedback    = val[FRAC_W-1:0];
                CFG_MIX_GAIN:      mix         = val[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Accepted input frame: predict its output and update the store
        function void note_frame(t_in f);
            t_addr   near_a, far_a;
            longint  fr, fb, mx, dry, near_s, far_s, dly;
            t_sample wet  [2];
            t_sample keep [2];
            t_out    want;
            near_a = write_pos - t_addr'(delay_whole);
            far_a  = near_a - t_addr'(1);
            fr = longint'(delay_frac);
            fb = (feedback > FEEDBACK_LIMIT) ? longint'(FEEDBACK_LIMIT) : longint'(feedback);
            mx = (mix > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(mix);
            for (int ch = 0; ch < 2; ch++) begin
                if (ch == 0) begin
                    dry    = longint'($signed(f.left_in));
                    near_s = longint'(left_mem[near_a]);
                    far_s  = longint'(left_mem[far_a]);
                end else begin
                    dry    = longint'($signed(f.right_in));
                    near_s = longint'(right_mem[near_a]);
                    far_s  = longint'(right_mem[far_a]);
                end
                dly      = round16(far_s * fr + near_s * (64'sd65536 - fr));
                wet[ch]  = clamp(round16(dry * (64'sd65536 - mx) + dly * mx));
                keep[ch] = clamp(dry + round16(dly * fb));
            end
            // reads of both taps happen before this frame's write
            left_mem[write_pos]  = keep[0];
            right_mem[write_pos] = keep[1];
            write_pos = write_pos + t_addr'(1);
            want.left_out  = wet[0];
            want.right_out = wet[1];
            expected_frames.push_back(want);
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        // Accepted output frame: compare with the oldest prediction
        task check_frame(t_out got);
            t_out want;
            if (expected_frames.size() == 0) begin
                report($sformatf("unexpected output frame L=%0d R=%0d",
                                 got.left_out, got.right_out));
                return;
            end
            want = expected_frames.pop_front();
            if (got.left_out !== want.left_out) begin
                report($sformatf("left_out got %0d expected %0d",
                                 got.left_out, want.left_out));
            end
            if (got.right_out !== want.right_out) begin
                report($sformatf("right_out got %0d expected %0d",
                                 got.right_out, want.right_out));
            end
        endtask
    endclass

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in                   in_data   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out                  o_out_data;
    logic                  o_cfg_ready;

    delay_scoreboard sb = new;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    int cycle_count = 0;

    stereo_feedback_delay dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever begin
            #1 i_clk = ~i_clk;
        end
    end

    // Output side: long hold-off when asked, else random stalls
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Result checking and run limit
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count++;
            if (o_out_valid && !out_stall) begin
                sb.check_frame(o_out_data);
            end
            if (cycle_count > CYCLE_LIMIT) begin
                $display("ERROR: timeout with %0d frames outstanding", sb.pending());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // One input request, with random idle cycles ahead of it
    task automatic send_frame(input t_sample l, input t_sample r);
        t_in f;
        f.left_in  = l;
        f.right_in = r;
        while ($urandom_range(99) < gap_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = f;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_frame(f);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until the block has drained
    task automatic settle();
        in_valid = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        sb.set_reg(idx, val);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] whole,
                                input logic [CFG_DATA_W-1:0] frac,
                                input logic [CFG_DATA_W-1:0] fb,
                                input logic [CFG_DATA_W-1:0] mx);
        settle();
        cfg_write(CFG_DELAY_WHOLE, whole);
        cfg_write(CFG_DELAY_FRAC, frac);
        cfg_write(CFG_FEEDBACK_GAIN, fb);
        cfg_write(CFG_MIX_GAIN, mx);
    endtask

    // Mostly full-range samples, some rails and some near zero
    function automatic t_sample rand_sample();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) return S_MAX;
        if (pick < 16) return S_MIN;
        if (pick < 30) return t_sample'($urandom_range(512)) - t_sample'(256);
        return t_sample'($urandom);
    endfunction

    initial begin
        int unsigned whole, frac, fb, mx;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: long delay, half mix
        send_frame(S_MAX, S_MIN);
        send_frame(S_MIN, S_MAX);
        send_frame(24'sd0, -24'sd1);

        // Zero whole delay, half-sample fraction, both gains above range
        apply_config(32'd0, 32'h8000, 32'hFFFF, 32'h1FFFF);
        cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
        send_frame(S_MAX, S_MAX);
        send_frame(S_MAX, S_MAX);
        send_frame(S_MIN, S_MIN);
        send_frame(24'sd1, -24'sd1);
        send_frame(S_MIN, S_MAX);
        send_frame(24'sd0, 24'sd0);

        // Oversized delay write (masks to the longest delay), top fraction, fully dry
        apply_config(32'hFFFF_FFFF, 32'd65535, 32'd64880, 32'd0);
        send_frame(S_MAX, S_MIN);
        send_frame(S_MIN, S_MAX);
        send_frame(-24'sd1, 24'sd1);
        send_frame(24'sd0, 24'sd0);

        // One-sample delay, fully wet, top feedback: store saturates
        apply_config(32'd1, 32'd0, 32'd64880, 32'd65536);
        repeat (4) send_frame(S_MAX, S_MIN);
        repeat (2) send_frame(24'sd0, 24'sd0);

        // Smallest nonzero gains and fraction
        apply_config(32'd2, 32'd1, 32'd1, 32'd1);
        send_frame(S_MIN, S_MAX);
        send_frame(S_MAX, S_MIN);
        send_frame(24'sd1, -24'sd1);
        send_frame(24'sd0, 24'sd0);

        // Random segments, two per idling mode
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            whole = ($urandom_range(5) == 0) ? $urandom_range(262143) : $urandom_range(48);
            case ($urandom_range(3))
                0:       frac = 0;
                1:       frac = 65535;
                default: frac = $urandom_range(65535);
            endcase
            fb = ($urandom_range(3) == 0) ? 64880 : $urandom_range(65535);
            mx = ($urandom_range(4) == 0) ? $urandom_range(131071, 65537)
                                          : $urandom_range(65536);
            apply_config(whole, frac, fb, mx);
            case (seg / 2)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 58; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 58; end
                default: begin gap_pct = 31; stall_pct = 31; end
            endcase
            for (int n = 0; n < SEG_FRAMES; n++) begin
                // block the output long enough to back up into the input
                if (seg == 0 && n == 10) begin
                    hold_left = HOLD_CYCLES;
                end
                // sender pause until everything has come out
                if (seg == 1 && n == 30) begin
                    settle();
                end
                send_frame(rand_sample(), rand_sample());
            end
        end

        in_valid = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
